/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the mixer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

/* hw/rtl/tvdm_pkg.sv */
// ----------------------------------------------------------------------------
// tvdm_pkg
// Types and constants of the two-voice ducking sample mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvdm_pkg;

  typedef enum logic [1:0] {
    REQ_MIX   = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_START = 2'd2
  } req_e;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  localparam logic [16:0]        MAX_LEN  = 17'h10000;
  localparam logic signed [15:0] SAT_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] SAT_MIN  = 16'sh8000;
  localparam logic signed [4:0]  NO_PRIO  = 5'sh1F;

  // 7/10 as 7 * ceil(2^24 / 10), exact for magnitudes up to 32768
  localparam logic [23:0] SCALE_MUL   = 24'd11744054;
  localparam int          SCALE_SHIFT = 24;
  localparam int          QUO_W       = 15;
  localparam logic [QUO_W-1:0] QUO_MAX = 15'd22937;

  typedef struct packed {
    logic               valid;
    logic               rd0;
    logic               rd1;
    logic               scale;
    logic signed [15:0] game_l;
    logic signed [15:0] game_r;
    logic               eob;
    logic signed [4:0]  active_prio;
  } mix_ctrl_t;

endpackage

/* hw/rtl/tvdm_ram.sv */
// ----------------------------------------------------------------------------
// tvdm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tvdm_mix.sv */
// ----------------------------------------------------------------------------
// tvdm_mix
// Voice scaling, summing, saturation and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tvdm_mix import tvdm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  mix_ctrl_t             ctrl_i,
  input  logic signed [15:0]    smp0_i,
  input  logic signed [15:0]    smp1_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  logic signed [15:0] v0, v1;
  logic               neg;
  logic [15:0]        mag;
  logic [39:0]        prod;

  mix_ctrl_t          ctrl_q;
  logic               s3_valid_q;
  logic signed [15:0] v0_q, v1_q;
  logic               neg_q;
  logic [QUO_W-1:0]   quo_q;

  logic signed [16:0] v1s;
  logic signed [17:0] voice;
  logic signed [18:0] sum_l, sum_r;
  logic signed [15:0] sat_l, sat_r;

  logic               out_valid_q;
  logic signed [15:0] out_l_q, out_r_q;
  logic signed [4:0]  out_ap_q;
  logic               out_last_q;

  // magnitude path: truncation toward zero
  assign v0   = ctrl_i.rd0 ? smp0_i : '0;
  assign v1   = ctrl_i.rd1 ? smp1_i : '0;
  assign neg  = v1[15];
  assign mag  = neg ? (~v1 + 16'd1) : v1;
  assign prod = 40'(mag) * 40'(SCALE_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q <= ctrl_i;
      v0_q   <= v0;
      v1_q   <= v1;
      neg_q  <= neg;
      quo_q  <= prod[SCALE_SHIFT+QUO_W-1:SCALE_SHIFT];
    end
  end

  always_comb begin
    if (ctrl_q.scale) begin
      v1s = neg_q ? -17'(quo_q) : 17'(quo_q);
    end else begin
      v1s = 17'(v1_q);
    end
    voice = 18'(v0_q) + 18'(v1s);
    sum_l = 19'(ctrl_q.game_l) + 19'(voice);
    sum_r = 19'(ctrl_q.game_r) + 19'(voice);
    if (sum_l > 19'(SAT_MAX)) begin
      sat_l = SAT_MAX;
    end else if (sum_l < 19'(SAT_MIN)) begin
      sat_l = SAT_MIN;
    end else begin
      sat_l = sum_l[15:0];
    end
    if (sum_r > 19'(SAT_MAX)) begin
      sat_r = SAT_MAX;
    end else if (sum_r < 19'(SAT_MIN)) begin
      sat_r = SAT_MIN;
    end else begin
      sat_r = sum_r[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_l_q    <= sat_l;
      out_r_q    <= sat_r;
      out_ap_q   <= ctrl_q.active_prio;
      out_last_q <= ctrl_q.eob;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {3'b000, out_ap_q, out_r_q, out_l_q};
  assign out_last_o  = out_last_q;

  `ASSERT_PROP(a_quo_range, clk_i, rst_ni, (s3_valid_q && ctrl_q.scale) |-> (quo_q <= QUO_MAX), "scaled voice out of range")
  `ASSERT_PROP(a_out_holds, clk_i, rst_ni, (out_valid_q && !en_i) |=> out_valid_q, "result dropped while stalled")

endmodule

/* hw/rtl/two_voice_ducking_sample_mixer_top.sv */
// A mix request's result passes the input, channel state, scaling and output registers.
// Throughput: one request per cycle; the pipeline and both clip RAM read
//   ports stall together only while the output register is full and not taken.
// Each channel has its own clip RAM copy, written together, read whenever not stalled.
// Reset clears the channel state and voice_enable; the clip memory is not
//   cleared and holds undefined data until written (no clearing pass).
// ----------------------------------------------------------------------------
// two_voice_ducking_sample_mixer_top
// Two-voice clip player mixed into a stereo game stream with ducking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_voice_ducking_sample_mixer_top import tvdm_pkg::*; #(
  parameter int CLIP_WORDS = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_wdata_i,   // voice_enable
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // game_left, game_right, mem_addr, mem_data, start_addr, clip_len, prio
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,  // req_type
  input  logic                  s_axis_tlast,  // end_of_buffer
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_left, out_right, active_prio
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast   // buffer_end
);

  localparam int              AW        = $clog2(CLIP_WORDS);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(CLIP_WORDS - 1);

  logic en;
  logic voice_enable_q;

  req_e        in_req;
  logic [15:0] in_x;

  logic               s1_valid_q;
  req_e               s1_req_q;
  logic signed [15:0] s1_gl_q, s1_gr_q, s1_data_q;
  logic               s1_eob_q;
  logic [15:0]        s1_x_q;
  logic [16:0]        s1_len_q;
  logic [3:0]         s1_prio_q;
  logic [AW-1:0]      s1_addr;

  logic [AW-1:0] addr_q [2];
  logic [AW-1:0] addr_d [2];
  logic [16:0]   rem_q  [2];
  logic [16:0]   rem_d  [2];
  logic [3:0]    prio_q [2];
  logic [3:0]    prio_d [2];

  mix_ctrl_t s2_d, s2_q;
  logic      ram_we;
  logic [15:0] smp0, smp1;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      voice_enable_q <= cfg_wdata_i;
    end
  end

  assign in_req = req_e'(s_axis_tuser);
  assign in_x   = (in_req == REQ_WRITE) ? s_axis_tdata[47:32] : s_axis_tdata[79:64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_req_q  <= in_req;
      s1_gl_q   <= s_axis_tdata[15:0];
      s1_gr_q   <= s_axis_tdata[31:16];
      s1_data_q <= s_axis_tdata[63:48];
      s1_eob_q  <= s_axis_tlast;
      s1_x_q    <= in_x;
      s1_len_q  <= s_axis_tdata[96:80];
      s1_prio_q <= s_axis_tdata[100:97];
    end
  end

  // address modulo CLIP_WORDS: reciprocal quotient, then subtract next stage
  if (CLIP_WORDS < 65536) begin : g_wrap
    localparam logic [63:0] RECIP64 =
      ((64'd1 << 32) + 64'(CLIP_WORDS) - 64'd1) / 64'(CLIP_WORDS);
    localparam logic [22:0] RECIP   = RECIP64[22:0];
    localparam logic [15:0] WORDS16 = 16'(CLIP_WORDS);
    logic [38:0] prod;
    logic [5:0]  quo_q;
    logic [15:0] rem;

    assign prod = 39'(in_x) * 39'(RECIP);

    always_ff @(posedge clk_i) begin
      if (en) begin
        quo_q <= prod[37:32];
      end
    end

    assign rem     = s1_x_q - 16'(quo_q * WORDS16);
    assign s1_addr = rem[AW-1:0];
  end else begin : g_nowrap
    assign s1_addr = AW'(s1_x_q);
  end

  always_comb begin
    logic ch;
    addr_d = addr_q;
    rem_d  = rem_q;
    prio_d = prio_q;
    ram_we = 1'b0;
    ch     = 1'b0;
    s2_d             = '0;
    s2_d.game_l      = s1_gl_q;
    s2_d.game_r      = s1_gr_q;
    s2_d.eob         = s1_eob_q;
    s2_d.active_prio = NO_PRIO;
    if (s1_valid_q) begin
      case (s1_req_q)
        REQ_WRITE: begin
          ram_we = 1'b1;
        end
        REQ_START: begin
          if (voice_enable_q) begin
            ch         = (s1_prio_q == 4'd0);
            addr_d[ch] = s1_addr;
            rem_d[ch]  = (s1_len_q > MAX_LEN) ? MAX_LEN : s1_len_q;
            prio_d[ch] = s1_prio_q;
          end
        end
        REQ_MIX: begin
          s2_d.valid = 1'b1;
          if (voice_enable_q) begin
            s2_d.rd0   = (rem_q[0] != '0);
            s2_d.rd1   = (rem_q[1] != '0);
            s2_d.scale = s2_d.rd1 && (rem_q[0] > 17'd1);
            for (int c = 0; c < 2; c++) begin
              if (rem_q[c] != '0) begin
                addr_d[c] = (addr_q[c] == LAST_ADDR) ? '0 : addr_q[c] + 1'b1;
                rem_d[c]  = rem_q[c] - 17'd1;
              end
            end
            if (rem_d[0] != '0) begin
              s2_d.active_prio = $signed({1'b0, prio_q[0]});
            end
            if (rem_d[1] != '0 && $signed({1'b0, prio_q[1]}) > s2_d.active_prio) begin
              s2_d.active_prio = $signed({1'b0, prio_q[1]});
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        addr_q[c] <= '0;
        rem_q[c]  <= '0;
        prio_q[c] <= '0;
      end
      s2_q <= '0;
    end else if (en) begin
      addr_q <= addr_d;
      rem_q  <= rem_d;
      prio_q <= prio_d;
      s2_q   <= s2_d;
    end
  end

  tvdm_ram #(
    .WIDTH (16),
    .DEPTH (CLIP_WORDS)
  ) u_ram0 (
    .clk_i   (clk_i),
    .we_i    (ram_we && en),
    .waddr_i (s1_addr),
    .wdata_i (s1_data_q),
    .re_i    (en),
    .raddr_i (addr_q[0]),
    .rdata_o (smp0)
  );

  tvdm_ram #(
    .WIDTH (16),
    .DEPTH (CLIP_WORDS)
  ) u_ram1 (
    .clk_i   (clk_i),
    .we_i    (ram_we && en),
    .waddr_i (s1_addr),
    .wdata_i (s1_data_q),
    .re_i    (en),
    .raddr_i (addr_q[1]),
    .rdata_o (smp1)
  );

  tvdm_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctrl_i      (s2_q),
    .smp0_i      (smp0),
    .smp1_i      (smp1),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  `ASSERT_PROP(a_rem_range, clk_i, rst_ni, (rem_q[0] <= MAX_LEN) && (rem_q[1] <= MAX_LEN), "channel length above maximum")
  `ASSERT_PROP(a_scale_both, clk_i, rst_ni, (s2_q.valid && s2_q.scale) |-> (s2_q.rd0 && s2_q.rd1), "ducking without both channels")
  `ASSERT_PROP(a_ready_empty, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "stalled with empty output")
  `ASSERT_PROP(a_no_result, clk_i, rst_ni, (en && !(s1_valid_q && s1_req_q == REQ_MIX)) |=> !s2_q.valid, "result from non-mix request")

endmodule
